>>> rtl/core/qmjt_pkg.sv
package qmjt_pkg;

  localparam int POS_WIDTH_DEF       = 32;
  localparam int PHASE_FRAC_BITS_DEF = 30;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int TICK_W = 32;
  localparam int AXIS_W = 3;

  // Pipeline depth from sample acceptance to result register.
  localparam int NUM_STAGES = 10;

  typedef enum logic [ADDR_W-3:0] {
    REG_START_TICK = 2'd0,
    REG_END_TICK   = 2'd1,
    REG_INV_DUR    = 2'd2
  } reg_idx_t;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [AXIS_W-1:0] axis_t;

endpackage

>>> rtl/core/qmjt_scale.sv
module qmjt_scale #(
  parameter int DW = 33,
  parameter int CW = 40,
  parameter int F  = 30
) (
  input  logic                    clk,
  input  logic [1:0]              en,
  input  logic signed [DW-1:0]    delta,
  input  logic signed [CW-1:0]    coef,
  output logic signed [DW+CW-F-1:0] q
);

  localparam int L   = CW / 2;
  localparam int H   = CW - L;
  localparam int PRW = DW + CW;

  logic signed [DW+L:0]    part_lo;
  logic signed [DW+H-1:0]  part_hi;
  logic                    neg;
  logic signed [PRW-1:0]   prod;
  logic signed [PRW-1:0]   prod_next;
  logic signed [L:0]       coef_lo;
  logic signed [H-1:0]     coef_hi;
  logic signed [DW+L:0]    part_lo_next;
  logic signed [DW+H-1:0]  part_hi_next;
  logic [PRW-1:0]          bias;

  always_comb begin
    coef_lo      = $signed({1'b0, coef[L-1:0]});
    coef_hi      = coef[CW-1:L];
    part_lo_next = delta * coef_lo;
    part_hi_next = delta * coef_hi;
  end

  // Bias a negative product so the arithmetic shift truncates toward zero.
  always_comb begin
    bias      = neg ? {{(PRW-F){1'b0}}, {F{1'b1}}} : '0;
    prod_next = PRW'(part_lo) + (PRW'(part_hi) <<< L) + $signed(bias);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      part_lo <= part_lo_next;
      part_hi <= part_hi_next;
      neg     <= delta[DW-1] ^ coef[CW-1];
    end
    if (en[1]) begin
      prod <= prod_next;
    end
  end

  assign q = $signed(prod[PRW-1:F]);

endmodule

>>> rtl/core/quintic_min_jerk_trajectory_unit.sv
// Minimum-jerk quintic trajectory interpolator, one axis sample per transaction.
// Sample channel: sample_valid/sample_stall carry sample_tick, axis_id, start_pos
// and end_pos. Result channel: result_valid/result_stall carry axis_tag,
// position_out, phase_velocity and phase_accel (derivatives with respect to phase).
// Configuration: APB-style writes to motion_start_tick (0x0), motion_end_tick (0x4)
// and inverse_duration (0x8); pready is always high, reads return the register.
// Write configuration only while no transaction is in flight.
// Throughput: one sample per clock while sample_stall is low. The result register
// is reached through the chain of phase-power multipliers and the two-step
// split products that scale the position delta.
// Reset clears the configuration registers and empties the pipeline.
// When the receiver stalls, the result register holds; earlier stages keep
// advancing into empty slots, and sample_stall rises only once all ten stages
// hold a transaction.
module quintic_min_jerk_trajectory_unit #(
  parameter int POS_WIDTH       = qmjt_pkg::POS_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = qmjt_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qmjt_pkg::ADDR_W-1:0]       paddr,
  input  logic [qmjt_pkg::DATA_W-1:0]       pwdata,
  output logic [qmjt_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  qmjt_pkg::tick_t                   sample_tick,
  input  qmjt_pkg::axis_t                   axis_id,
  input  logic signed [POS_WIDTH-1:0]       start_pos,
  input  logic signed [POS_WIDTH-1:0]       end_pos,
  output logic                              result_valid,
  input  logic                              result_stall,
  output qmjt_pkg::axis_t                   axis_tag,
  output logic signed [POS_WIDTH-1:0]       position_out,
  output logic signed [POS_WIDTH+3:0]       phase_velocity,
  output logic signed [POS_WIDTH+3:0]       phase_accel
);

  localparam int NST  = qmjt_pkg::NUM_STAGES;
  localparam int F    = PHASE_FRAC_BITS;
  localparam int TW   = F + 1;
  localparam int CW   = F + 10;
  localparam int DW   = POS_WIDTH + 1;
  localparam int QW   = DW + CW - F;
  localparam int DERW = POS_WIDTH + 4;
  localparam int TK   = qmjt_pkg::TICK_W;

  localparam logic [TW-1:0]        ONE_T = TW'(1) << F;
  localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;
  localparam logic signed [QW-1:0] DMAX  = {{(QW-DERW+1){1'b0}}, {(DERW-1){1'b1}}};
  localparam logic signed [QW-1:0] DMIN  = ~DMAX;

  // Configuration registers
  qmjt_pkg::tick_t start_tick;
  qmjt_pkg::tick_t end_tick;
  qmjt_pkg::tick_t inv_dur;
  qmjt_pkg::reg_idx_t reg_sel;

  assign reg_sel = qmjt_pkg::reg_idx_t'(paddr[qmjt_pkg::ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_tick <= '0;
      end_tick   <= '0;
      inv_dur    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        qmjt_pkg::REG_START_TICK: start_tick <= pwdata;
        qmjt_pkg::REG_END_TICK:   end_tick   <= pwdata;
        qmjt_pkg::REG_INV_DUR:    inv_dur    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      qmjt_pkg::REG_START_TICK: prdata = start_tick;
      qmjt_pkg::REG_END_TICK:   prdata = end_tick;
      qmjt_pkg::REG_INV_DUR:    prdata = inv_dur;
      default:                  prdata = '0;
    endcase
  end

  // Pipeline flow control
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || !result_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign sample_stall = !en[0];
  assign result_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= sample_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Side-band carried alongside the phase arithmetic
  qmjt_pkg::axis_t             axis_sr  [0:NST-2];
  logic signed [POS_WIDTH-1:0] p0_sr    [0:NST-2];
  logic signed [DW-1:0]        delta_sr [0:6];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      axis_sr[0]  <= axis_id;
      p0_sr[0]    <= start_pos;
      delta_sr[0] <= DW'(end_pos) - DW'(start_pos);
    end
    for (int i = 1; i < NST - 1; i++) begin
      if (en[i]) begin
        axis_sr[i] <= axis_sr[i-1];
        p0_sr[i]   <= p0_sr[i-1];
      end
    end
    for (int i = 1; i < 7; i++) begin
      if (en[i]) delta_sr[i] <= delta_sr[i-1];
    end
  end

  // Stage 0: clamp time, elapsed ticks
  qmjt_pkg::tick_t t_clamp;
  qmjt_pkg::tick_t elapsed0;
  logic            active0;

  assign t_clamp = (sample_tick > end_tick) ? end_tick : sample_tick;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      elapsed0 <= t_clamp - start_tick;
      active0  <= (t_clamp >= start_tick);
    end
  end

  // Stage 1: phase product
  logic [2*TK-1:0] prod1;
  logic            active1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1   <= elapsed0 * inv_dur;
      active1 <= active0;
    end
  end

  // Stage 2: phase in fixed point, square
  logic [TK+F-1:0]  frac_w;
  logic [TW-1:0]    tau_n;
  logic [2*TW-1:0]  sq_n;
  logic [TW-1:0]    tau2, t2_2;

  always_comb begin
    frac_w = {prod1[TK-1:0], {F{1'b0}}} >> TK;
    if (!active1) begin
      tau_n = '0;
    end else if (|prod1[2*TK-1:TK]) begin
      tau_n = ONE_T;
    end else begin
      tau_n = {1'b0, frac_w[F-1:0]};
    end
    sq_n = tau_n * tau_n;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tau2 <= tau_n;
      t2_2 <= sq_n[F +: TW];
    end
  end

  // Stages 3 to 5: higher powers
  logic [2*TW-1:0] m3, m4, m5;
  logic [TW-1:0]   tau3, t2_3, t3_3;
  logic [TW-1:0]   tau4, t2_4, t3_4, t4_4;
  logic [TW-1:0]   tau5, t2_5, t3_5, t4_5, t5_5;

  always_comb begin
    m3 = t2_2 * tau2;
    m4 = t3_3 * tau3;
    m5 = t4_4 * tau4;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      tau3 <= tau2;
      t2_3 <= t2_2;
      t3_3 <= m3[F +: TW];
    end
    if (en[4]) begin
      tau4 <= tau3;
      t2_4 <= t2_3;
      t3_4 <= t3_3;
      t4_4 <= m4[F +: TW];
    end
    if (en[5]) begin
      tau5 <= tau4;
      t2_5 <= t2_4;
      t3_5 <= t3_4;
      t4_5 <= t4_4;
      t5_5 <= m5[F +: TW];
    end
  end

  // Stage 6: shape polynomials
  logic signed [CW-1:0] e1, e2, e3, e4, e5;
  logic signed [CW-1:0] s_n, vel_n, acc_n, s_clip;
  logic signed [CW-1:0] s_c, vel_c, acc_c;

  always_comb begin
    e1     = $signed(CW'(tau5));
    e2     = $signed(CW'(t2_5));
    e3     = $signed(CW'(t3_5));
    e4     = $signed(CW'(t4_5));
    e5     = $signed(CW'(t5_5));
    s_n    = CW'(6) * e5 - CW'(15) * e4 + CW'(10) * e3;
    vel_n  = CW'(30) * e4 - CW'(60) * e3 + CW'(30) * e2;
    acc_n  = CW'(120) * e3 - CW'(180) * e2 + CW'(60) * e1;
    s_clip = s_n;
    if (s_n < 0) begin
      s_clip = '0;
    end else if (s_n > ONE_C) begin
      s_clip = ONE_C;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s_c   <= s_clip;
      vel_c <= vel_n;
      acc_c <= acc_n;
    end
  end

  // Stages 7 and 8: delta times shape, split products
  logic signed [QW-1:0] q_s, q_v, q_a;

  qmjt_scale #(.DW(DW), .CW(CW), .F(F)) u_scale_pos (
    .clk(clk), .en(en[8:7]), .delta(delta_sr[6]), .coef(s_c), .q(q_s)
  );

  qmjt_scale #(.DW(DW), .CW(CW), .F(F)) u_scale_vel (
    .clk(clk), .en(en[8:7]), .delta(delta_sr[6]), .coef(vel_c), .q(q_v)
  );

  qmjt_scale #(.DW(DW), .CW(CW), .F(F)) u_scale_acc (
    .clk(clk), .en(en[8:7]), .delta(delta_sr[6]), .coef(acc_c), .q(q_a)
  );

  // Stage 9: result register
  logic signed [DERW-1:0] vel_sat, acc_sat;

  always_comb begin
    if (q_v > DMAX) begin
      vel_sat = DMAX[DERW-1:0];
    end else if (q_v < DMIN) begin
      vel_sat = DMIN[DERW-1:0];
    end else begin
      vel_sat = q_v[DERW-1:0];
    end
    if (q_a > DMAX) begin
      acc_sat = DMAX[DERW-1:0];
    end else if (q_a < DMIN) begin
      acc_sat = DMIN[DERW-1:0];
    end else begin
      acc_sat = q_a[DERW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      axis_tag       <= axis_sr[NST-2];
      position_out   <= p0_sr[NST-2] + $signed(q_s[POS_WIDTH-1:0]);
      phase_velocity <= vel_sat;
      phase_accel    <= acc_sat;
    end
  end

endmodule

>>> rtl/core/qmjt_check.sv
module qmjt_check #(
  parameter int POS_WIDTH = qmjt_pkg::POS_WIDTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        sample_valid,
  input logic                        sample_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input qmjt_pkg::axis_t             axis_tag,
  input logic signed [POS_WIDTH-1:0] position_out,
  input logic signed [POS_WIDTH+3:0] phase_velocity,
  input logic signed [POS_WIDTH+3:0] phase_accel
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set after reset");

  // Input back-pressure only when the output is stalled with a result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample_stall without a stalled result");

  // A free output never blocks the input.
  a_free_accept: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || !result_stall) |-> !sample_stall)
    else $error("sample_stall while the result side is free");

  // Stalled result transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(axis_tag) && $stable(position_out) &&
       $stable(phase_velocity) && $stable(phase_accel)))
    else $error("stalled result changed");

endmodule

bind quintic_min_jerk_trajectory_unit qmjt_check #(.POS_WIDTH(POS_WIDTH)) u_qmjt_check (.*);

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int PW = qmjt_pkg::POS_WIDTH_DEF;
  localparam int FB = qmjt_pkg::PHASE_FRAC_BITS_DEF;
  localparam int DW = PW + 4;
  localparam logic [63:0] PHASE_ONE = 64'd1 << FB;
  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct {
    qmjt_pkg::tick_t tick;
    qmjt_pkg::axis_t axis;
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
  } axis_sample_t;

  typedef struct {
    qmjt_pkg::axis_t axis;
    logic signed [PW-1:0] pos;
    logic signed [DW-1:0] vel;
    logic signed [DW-1:0] acc;
  } traj_point_t;

  class traj_scoreboard;
    qmjt_pkg::tick_t start_tick;
    qmjt_pkg::tick_t end_tick;
    logic [31:0] inv_duration;
    traj_point_t pending[$];
    int errors;

    function new();
      start_tick = '0;
      end_tick = '0;
      inv_duration = '0;
      errors = 0;
    endfunction

    function void set_reg(qmjt_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        qmjt_pkg::REG_START_TICK: start_tick = value;
        qmjt_pkg::REG_END_TICK: end_tick = value;
        qmjt_pkg::REG_INV_DUR: inv_duration = value;
        default: ;
      endcase
    endfunction

    function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[FB+63:FB];
    endfunction

    function longint scale_trunc(longint d, longint c);
      logic neg;
      logic [63:0] md;
      logic [63:0] mc;
      logic [127:0] p;
      neg = (d < 0) != (c < 0);
      md = (d < 0) ? -d : d;
      mc = (c < 0) ? -c : c;
      p = {64'd0, md} * {64'd0, mc};
      return neg ? -longint'(p[FB+63:FB]) : longint'(p[FB+63:FB]);
    endfunction

    function logic signed [DW-1:0] sat_der(longint v);
      longint lim;
      lim = longint'(1) <<< (DW - 1);
      if (v > lim - 1) v = lim - 1;
      else if (v < -lim) v = -lim;
      return v[DW-1:0];
    endfunction

    function traj_point_t eval_point(axis_sample_t s);
      qmjt_pkg::tick_t t_now;
      qmjt_pkg::tick_t elapsed;
      logic [63:0] prod;
      logic [63:0] tau;
      logic [63:0] t2;
      logic [63:0] t3;
      logic [63:0] t4;
      logic [63:0] t5;
      longint delta;
      longint shape;
      longint vel_poly;
      longint acc_poly;
      longint pos;
      traj_point_t r;
      t_now = (s.tick > end_tick) ? end_tick : s.tick;
      tau = '0;
      if (t_now >= start_tick) begin
        elapsed = t_now - start_tick;
        prod = {32'd0, elapsed} * {32'd0, inv_duration};
        if (prod[63:32] != '0) tau = PHASE_ONE;
        else tau = prod >> (32 - FB);
        if (tau > PHASE_ONE) tau = PHASE_ONE;
      end
      t2 = frac_mul(tau, tau);
      t3 = frac_mul(t2, tau);
      t4 = frac_mul(t3, tau);
      t5 = frac_mul(t4, tau);
      shape = 6 * longint'(t5) - 15 * longint'(t4) + 10 * longint'(t3);
      if (shape < 0) shape = 0;
      if (shape > longint'(PHASE_ONE)) shape = longint'(PHASE_ONE);
      vel_poly = 30 * longint'(t4) - 60 * longint'(t3) + 30 * longint'(t2);
      acc_poly = 120 * longint'(t3) - 180 * longint'(t2) + 60 * longint'(tau);
      delta = longint'(s.p1) - longint'(s.p0);
      pos = longint'(s.p0) + scale_trunc(delta, shape);
      r.axis = s.axis;
      r.pos = pos[PW-1:0];
      r.vel = sat_der(scale_trunc(delta, vel_poly));
      r.acc = sat_der(scale_trunc(delta, acc_poly));
      return r;
    endfunction

    function void note_sample(axis_sample_t s);
      pending.push_back(eval_point(s));
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_result(traj_point_t got);
      traj_point_t want;
      if (pending.size() == 0) begin
        report("result transaction with no sample outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.axis !== want.axis)
        report($sformatf("axis_tag %0d, expected %0d", got.axis, want.axis));
      if (got.pos !== want.pos)
        report($sformatf("position_out %0d, expected %0d", got.pos, want.pos));
      if (got.vel !== want.vel)
        report($sformatf("phase_velocity %0d, expected %0d", got.vel, want.vel));
      if (got.acc !== want.acc)
        report($sformatf("phase_accel %0d, expected %0d", got.acc, want.acc));
    endtask
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [qmjt_pkg::ADDR_W-1:0] paddr;
  logic [qmjt_pkg::DATA_W-1:0] pwdata;
  logic [qmjt_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic sample_valid;
  logic sample_stall;
  qmjt_pkg::tick_t sample_tick;
  qmjt_pkg::axis_t axis_id;
  logic signed [PW-1:0] start_pos;
  logic signed [PW-1:0] end_pos;
  logic result_valid;
  logic result_stall;
  qmjt_pkg::axis_t axis_tag;
  logic signed [PW-1:0] position_out;
  logic signed [DW-1:0] phase_velocity;
  logic signed [DW-1:0] phase_accel;

  traj_scoreboard sb = new();
  traj_point_t seen_point;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left = 0;

  quintic_min_jerk_trajectory_unit dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_tick(sample_tick),
    .axis_id(axis_id),
    .start_pos(start_pos),
    .end_pos(end_pos),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .axis_tag(axis_tag),
    .position_out(position_out),
    .phase_velocity(phase_velocity),
    .phase_accel(phase_accel)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen_point.axis = axis_tag;
      seen_point.pos = position_out;
      seen_point.vel = phase_velocity;
      seen_point.acc = phase_accel;
      sb.check_result(seen_point);
    end
    if (stall_left > 0 && recv_idle_pct != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      stall_left = $urandom_range(0, 14);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic write_reg(qmjt_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] st, logic [31:0] fin, logic [31:0] inv);
    write_reg(qmjt_pkg::REG_START_TICK, st);
    write_reg(qmjt_pkg::REG_END_TICK, fin);
    write_reg(qmjt_pkg::REG_INV_DUR, inv);
  endtask

  // hold off new samples until every outstanding result has been taken
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 15) : 0;
  endfunction

  task automatic send_item(axis_sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_tick <= s.tick;
    axis_id <= s.axis;
    start_pos <= s.p0;
    end_pos <= s.p1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic send_fields(qmjt_pkg::tick_t t, qmjt_pkg::axis_t a,
                             logic signed [PW-1:0] p0, logic signed [PW-1:0] p1);
    axis_sample_t s;
    s.tick = t;
    s.axis = a;
    s.p0 = p0;
    s.p1 = p1;
    send_item(s);
  endtask

  function automatic logic signed [PW-1:0] random_pos();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      1: return PW'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic axis_sample_t random_sample();
    axis_sample_t s;
    qmjt_pkg::tick_t span;
    int pick;
    span = sb.end_tick - sb.start_tick;
    pick = $urandom_range(0, 19);
    if (pick < 13)
      s.tick = sb.start_tick
             + qmjt_pkg::tick_t'(64'($urandom()) % (64'(span) + 64'd1));
    else if (pick < 15) s.tick = sb.start_tick - $urandom_range(1, 64);
    else if (pick < 17) s.tick = sb.end_tick + $urandom_range(0, 64);
    else if (pick < 18) s.tick = sb.start_tick;
    else s.tick = $urandom();
    s.axis = qmjt_pkg::axis_t'($urandom_range(0, 5));
    s.p0 = random_pos();
    s.p1 = ($urandom_range(0, 9) == 0) ? s.p0 : random_pos();
    return s;
  endfunction

  task automatic pick_config(int mode);
    logic [31:0] st;
    logic [31:0] dur;
    logic [63:0] inv;
    st = $urandom();
    dur = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 4096);
    if (dur == 0) dur = 1;
    inv = 64'h1_0000_0000 / {32'd0, dur};
    if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
    case (mode)
      3: begin
        inv = inv + 64'($urandom_range(1, 1 << 20));
        if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
      end
      4: inv = inv - (64'($urandom()) % ((inv >> 4) + 64'd1));
      5: begin
        dur = $urandom();
        inv = 64'($urandom());
      end
      default: ;
    endcase
    load_config(st, st + dur, inv[31:0]);
  endtask

  initial begin
    int ph;
    int i;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sample_valid <= 1'b0;
    sample_tick <= '0;
    axis_id <= '0;
    start_pos <= '0;
    end_pos <= '0;
    result_stall <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    load_config(32'd1000, 32'd2024, 32'h0040_0000);
    send_fields(32'd0, 3'd0, POS_MIN, POS_MAX);
    send_fields(32'd999, 3'd1, POS_MAX, POS_MIN);
    send_fields(32'd1000, 3'd2, POS_MIN, POS_MAX);
    send_fields(32'd1001, 3'd3, -PW'(1000), PW'(1000));
    send_fields(32'd1256, 3'd4, POS_MIN, POS_MAX);
    send_fields(32'd1512, 3'd5, POS_MAX, POS_MIN);
    send_fields(32'd1768, 3'd0, '0, '0);
    send_fields(32'd2023, 3'd1, POS_MIN, POS_MAX);
    send_fields(32'd2024, 3'd2, POS_MAX, POS_MIN);
    send_fields(32'd2025, 3'd3, PW'(12345), PW'(12345));
    send_fields(32'hFFFF_FFFF, 3'd4, POS_MIN, POS_MAX);
    send_fields(32'd1512, 3'd5, -PW'(1), '0);

    // end tick before start tick
    drain();
    load_config(32'd5000, 32'd100, 32'h0040_0000);
    send_fields(32'd0, 3'd0, POS_MIN, POS_MAX);
    send_fields(32'd100, 3'd1, POS_MAX, POS_MIN);
    send_fields(32'd5000, 3'd2, POS_MIN, POS_MAX);
    send_fields(32'hFFFF_FFFF, 3'd3, POS_MAX, POS_MIN);

    // oversized reciprocal: phase saturates at one
    drain();
    load_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(32'd0, 3'd4, POS_MIN, POS_MAX);
    send_fields(32'd1, 3'd5, POS_MIN, POS_MAX);
    send_fields(32'd2, 3'd0, POS_MAX, POS_MIN);
    send_fields(32'hFFFF_FFFF, 3'd1, POS_MIN, POS_MAX);

    drain();
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_fields(32'd0, 3'd2, POS_MIN, POS_MAX);
    send_fields(32'hFFFF_FFFF, 3'd3, POS_MAX, POS_MIN);

    drain();
    load_config(32'd0, 32'd0, 32'h8000_0000);
    send_fields(32'd0, 3'd4, POS_MIN, POS_MAX);
    send_fields(32'hFFFF_FFFF, 3'd5, POS_MAX, POS_MIN);

    for (ph = 0; ph < 9; ph++) begin
      drain();
      pick_config(ph % 6);
      if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      for (i = 0; i < 200; i++) begin
        if (ph == 4 && i == 100) drain();
        send_item(random_sample());
      end
    end

    drain();
    repeat (qmjt_pkg::NUM_STAGES + 4) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
